// File: rtl/gtrav_pkg.sv
// shared types, command codes and defaults for the graph traversal engine
`default_nettype none

package gtrav_pkg;

   // default number of vertices held in the adjacency matrix
   localparam int MAX_NODES_DEF = 16;

   // field widths
   localparam int VERTEX_W   = 4;
   localparam int CMD_W      = 2;
   localparam int VCOUNT_W   = 5;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BFS   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_DFS   = 2'd3;

   typedef logic [VERTEX_W-1:0] vertex_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;      // request taken, apply its command
      logic step;      // take the found neighbor, send the held vertex
      logic pop;       // read the next queue or stack entry
      logic load_cur;  // popped entry becomes the current vertex
      logic flush;     // send the held vertex as the final one
   } ctl_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic found;     // current vertex has an unvisited neighbor in range
      logic empty;     // queue or stack holds nothing
      logic out_free;  // result register can take a vertex this cycle
      logic req_trav;  // waiting request is a traversal
      logic req_oob;   // waiting request starts beyond the matrix
   } sts_type;

endpackage

`default_nettype wire

// File: rtl/gtrav_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module gtrav_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/gtrav_ctrl.sv
// traversal controller: request handshake and sequencing of the datapath
`default_nettype none

module gtrav_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire gtrav_pkg::sts_type sts,
   output gtrav_pkg::ctl_type     ctl
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_LOAD  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // no request is taken while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               ctl.load = 1'b1;
               if (sts.req_trav) begin
                  state_in = sts.req_oob ? ST_FLUSH : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (sts.found) begin
               ctl.step = sts.out_free;
            end else if (sts.empty) begin
               state_in = ST_FLUSH;
            end else begin
               ctl.pop  = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctl.load_cur = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               ctl.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a traversal request always leads into a scan or straight to the final vertex
   a_trav_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && sts.req_trav) |=>
         (state_ff == ST_SCAN || state_ff == ST_FLUSH))
      else $error("traversal request did not start a traversal");

   // a pop is always followed by loading the popped vertex
   a_pop_load: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |=> ctl.load_cur)
      else $error("popped entry not loaded");

   // never two datapath actions at once
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.load, ctl.step, ctl.pop, ctl.load_cur, ctl.flush}))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// File: rtl/gtrav_dp.sv
// traversal datapath: adjacency matrix, visited marks, queue/stack and result register
`default_nettype none

module gtrav_dp #(
   parameter int MAX_NODES = gtrav_pkg::MAX_NODES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [gtrav_pkg::CMD_W-1:0]        req_cmd,
   input  wire gtrav_pkg::vertex_type              req_first,
   input  wire gtrav_pkg::vertex_type              req_second,
   input  wire logic                               csr_wr_en,
   input  wire logic [gtrav_pkg::VCOUNT_W-1:0]     csr_wr_data,
   input  wire gtrav_pkg::ctl_type                 ctl,
   output gtrav_pkg::sts_type                      sts,
   input  wire logic                               rsp_tready,
   output logic                                    rsp_tvalid,
   output gtrav_pkg::vertex_type                   rsp_vertex,
   output logic                                    rsp_last
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);

   typedef logic [NW-1:0]        node_type;
   typedef logic [MAX_NODES-1:0] row_type;

   row_type                          rows_ff [MAX_NODES];
   row_type                          rows_in [MAX_NODES];
   row_type                          visited_ff, visited_in;
   logic [gtrav_pkg::VCOUNT_W-1:0]   vcount_ff;
   gtrav_pkg::vertex_type            hold_ff, hold_in;
   node_type                         cur_ff, cur_in;
   logic                             dfs_ff, dfs_in;
   logic [CW-1:0]                    head_ff, head_in;
   logic [CW-1:0]                    top_ff, top_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   gtrav_pkg::vertex_type            rsp_vertex_ff;
   logic                             rsp_last_ff;

   row_type                          col_mask;
   row_type                          cand;
   node_type                         found_idx;
   logic                             first_ok, second_ok;
   logic                             is_trav, out_free, emit;
   logic                             ram_wr_en;
   logic [NW-1:0]                    ram_wr_addr, ram_rd_addr;
   node_type                         ram_wr_data, ram_rd_data;
   logic [CW-1:0]                    top_dec;

   // request decode
   assign first_ok  = 32'(req_first) < 32'(MAX_NODES);
   assign second_ok = 32'(req_second) < 32'(MAX_NODES);
   assign is_trav   = (req_cmd == gtrav_pkg::CMD_BFS) || (req_cmd == gtrav_pkg::CMD_DFS);

   // columns below the configured vertex count
   always_comb begin
      for (int j = 0; j < MAX_NODES; j++) begin
         col_mask[j] = 32'(j) < 32'(vcount_ff);
      end
   end

   // lowest unvisited neighbor of the current vertex
   assign cand = rows_ff[cur_ff] & ~visited_ff & col_mask;

   always_comb begin
      found_idx = '0;
      for (int j = MAX_NODES - 1; j >= 0; j--) begin
         if (cand[j]) begin
            found_idx = node_type'(j);
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = ctl.step || ctl.flush;
   assign top_dec  = top_ff - CW'(1);

   // status to the controller
   always_comb begin
      sts          = '0;
      sts.found    = |cand;
      sts.empty    = head_ff == top_ff;
      sts.out_free = out_free;
      sts.req_trav = is_trav;
      sts.req_oob  = !first_ok;
   end

   // matrix updates for clear and add edge
   always_comb begin
      rows_in = rows_ff;
      if (ctl.load && req_cmd == gtrav_pkg::CMD_CLEAR) begin
         for (int r = 0; r < MAX_NODES; r++) begin
            rows_in[r] = '0;
         end
      end else if (ctl.load && req_cmd == gtrav_pkg::CMD_ADD && first_ok && second_ok) begin
         rows_in[node_type'(req_first)][node_type'(req_second)] = 1'b1;
         rows_in[node_type'(req_second)][node_type'(req_first)] = 1'b1;
      end
   end

   // traversal state updates
   always_comb begin
      visited_in = visited_ff;
      hold_in    = hold_ff;
      cur_in     = cur_ff;
      dfs_in     = dfs_ff;
      head_in    = head_ff;
      top_in     = top_ff;
      if (ctl.load) begin
         if (req_cmd == gtrav_pkg::CMD_CLEAR) begin
            visited_in = '0;
         end else if (is_trav) begin
            visited_in = '0;
            if (first_ok) begin
               visited_in[node_type'(req_first)] = 1'b1;
            end
            hold_in = req_first;
            cur_in  = node_type'(req_first);
            dfs_in  = req_cmd == gtrav_pkg::CMD_DFS;
            head_in = '0;
            top_in  = '0;
         end
      end else if (ctl.step) begin
         visited_in[found_idx] = 1'b1;
         hold_in = gtrav_pkg::vertex_type'(found_idx);
         top_in  = top_ff + CW'(1);
         if (dfs_ff) begin
            cur_in = found_idx;
         end
      end else if (ctl.pop) begin
         if (dfs_ff) begin
            top_in = top_dec;
         end else begin
            head_in = head_ff + CW'(1);
         end
      end else if (ctl.load_cur) begin
         cur_in = ram_rd_data;
      end
   end

   // queue and stack share one ram: bfs pushes found vertices, dfs pushes the parent
   assign ram_wr_en   = ctl.step;
   assign ram_wr_addr = top_ff[NW-1:0];
   assign ram_wr_data = dfs_ff ? cur_ff : found_idx;
   assign ram_rd_addr = dfs_ff ? top_dec[NW-1:0] : head_ff[NW-1:0];

   gtrav_ram #(
      .WIDTH (NW),
      .DEPTH (MAX_NODES)
   ) u_pend_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ctl.pop),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MAX_NODES; r++) begin
            rows_ff[r] <= '0;
         end
         visited_ff   <= '0;
         vcount_ff    <= gtrav_pkg::VCOUNT_RESET;
         head_ff      <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         visited_ff   <= visited_in;
         head_ff      <= head_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      cur_ff  <= cur_in;
      dfs_ff  <= dfs_in;
      if (emit) begin
         rsp_vertex_ff <= hold_ff;
         rsp_last_ff   <= ctl.flush;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_last   = rsp_last_ff;

   // a vertex is only sent when the result register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result overwritten before it was taken");

   // the final vertex shows up flagged in the next cycle
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      ctl.flush |=> (rsp_tvalid && rsp_last))
      else $error("final vertex not flagged");

   // queue read pointer never passes the write pointer
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= top_ff)
      else $error("queue head passed tail");

endmodule

`default_nettype wire

// File: rtl/graph_bfs_dfs_traversal.sv
// Graph traversal engine over a bit adjacency matrix (top level).
//
// Requests arrive on req_*: req_tuser carries the command (clear, add edge,
// breadth-first, depth-first), req_tdata the two vertex numbers. Results
// leave on rsp_*: rsp_tdata carries the visited vertex, rsp_tlast marks the
// final vertex of a traversal. Clear and add edge give no result. A
// traversal runs over the matrix one neighbor search per cycle while the
// receiver keeps up; the search waits while the result register is full.
// Each vertex taken from the queue or stack is popped with a registered read
// of the queue/stack memory and then loaded as the current vertex; once the
// queue or stack is found empty, the final vertex is sent.
// The start vertex is sent first: by the scan that follows the request when
// it has a neighbor in range, else as the final vertex from the flush
// state.
// New requests are taken only once the final vertex of the previous
// traversal has been placed in the result register.
// The result register holds its vertex while rsp_tready is low; the search
// then waits and nothing is dropped. Reset clears the matrix, the visited
// marks and the result register, and sets the vertex count to 16.
// csr_wr_en writes the vertex count; write it only while no traversal runs.
`default_nettype none

module graph_bfs_dfs_traversal #(
   parameter int MAX_NODES = gtrav_pkg::MAX_NODES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [gtrav_pkg::REQ_DATA_W-1:0]    req_tdata,  // first_vertex, second_vertex
   input  wire logic [gtrav_pkg::CMD_W-1:0]         req_tuser,  // cmd
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [gtrav_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // visited_vertex, zero pad
   output logic                                     rsp_tlast,  // last_vertex
   input  wire logic                                csr_wr_en,
   input  wire logic [gtrav_pkg::VCOUNT_W-1:0]      csr_wr_data
);

   gtrav_pkg::ctl_type    ctl;
   gtrav_pkg::sts_type    sts;
   gtrav_pkg::vertex_type req_first, req_second, rsp_vertex;

   // request field unpacking
   assign req_first  = req_tdata[gtrav_pkg::VERTEX_W-1:0];
   assign req_second = req_tdata[2*gtrav_pkg::VERTEX_W-1:gtrav_pkg::VERTEX_W];

   gtrav_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   gtrav_dp #(
      .MAX_NODES (MAX_NODES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_cmd     (req_tuser),
      .req_first   (req_first),
      .req_second  (req_second),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctl         (ctl),
      .sts         (sts),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_vertex  (rsp_vertex),
      .rsp_last    (rsp_tlast)
   );

   // result packing
   assign rsp_tdata = {{(gtrav_pkg::RSP_DATA_W-gtrav_pkg::VERTEX_W){1'b0}}, rsp_vertex};

endmodule

`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench for the graph traversal engine: directed table, then random graphs
module testbench;
   import gtrav_pkg::*;

   localparam int NODES         = MAX_NODES_DEF;
   localparam int IDLE_LIMIT    = 5000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 10;
   localparam int TAIL_CYCLES   = 40;
   localparam int RANDOM_ITEMS  = 400;
   localparam int MAX_GAP       = 12;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 24;

   // one emitted vertex as it should appear on the result channel
   typedef struct packed {
      vertex_type vertex;
      logic       last;
   } visit_type;

   // one row of the directed table; typed rows carry a single final vertex
   typedef struct {
      bit                  set_count;
      logic [VCOUNT_W-1:0] count;
      logic [CMD_W-1:0]    cmd;
      vertex_type          first;
      vertex_type          second;
      bit                  typed;
      vertex_type          typed_vertex;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // first_vertex, second_vertex
   logic [CMD_W-1:0]      req_tuser;   // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // visited_vertex, zero pad
   logic                  rsp_tlast;   // last_vertex
   logic                  csr_wr_en;
   logic [VCOUNT_W-1:0]   csr_wr_data;

   // model of the matrix and the vertex count register
   logic [NODES-1:0]    edge_rows [NODES];
   logic [VCOUNT_W-1:0] vertex_count_model;
   visit_type           pending_visits [$];
   visit_type           expected_visit;

   bit source_idle  = 1'b1;
   bit sink_idle    = 1'b1;
   bit hold_request = 1'b0;

   int idle_cycles     = 0;
   int error_count     = 0;
   int requests_sent   = 0;
   int traversals_sent = 0;
   int visits_checked  = 0;
   int count_writes    = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // empty graph right after reset: start only
      '{1'b0, 5'd0,  CMD_BFS,   4'd0,  4'd0,  1'b1, 4'd0},
      '{1'b0, 5'd0,  CMD_DFS,   4'd15, 4'd9,  1'b1, 4'd15},
      // small graph with a self loop on vertex 5
      '{1'b0, 5'd0,  CMD_ADD,   4'd0,  4'd1,  1'b0, 4'd0},
      '{1'b0, 5'd0,  CMD_ADD,   4'd2,  4'd1,  1'b0, 4'd0},
      '{1'b0, 5'd0,  CMD_ADD,   4'd0,  4'd3,  1'b0, 4'd0},
      '{1'b0, 5'd0,  CMD_ADD,   4'd15, 4'd2,  1'b0, 4'd0},
      '{1'b0, 5'd0,  CMD_ADD,   4'd5,  4'd5,  1'b0, 4'd0},
      '{1'b0, 5'd0,  CMD_ADD,   4'd14, 4'd15, 1'b0, 4'd0},
      '{1'b0, 5'd0,  CMD_ADD,   4'd3,  4'd14, 1'b0, 4'd0},
      '{1'b0, 5'd0,  CMD_BFS,   4'd0,  4'd7,  1'b0, 4'd0},
      '{1'b0, 5'd0,  CMD_DFS,   4'd0,  4'd15, 1'b0, 4'd0},
      // self loop never revisits
      '{1'b0, 5'd0,  CMD_DFS,   4'd5,  4'd0,  1'b1, 4'd5},
      '{1'b0, 5'd0,  CMD_BFS,   4'd5,  4'd15, 1'b1, 4'd5},
      // vertex count zero: nothing scanned
      '{1'b1, 5'd0,  CMD_BFS,   4'd0,  4'd0,  1'b1, 4'd0},
      '{1'b0, 5'd0,  CMD_DFS,   4'd15, 4'd0,  1'b1, 4'd15},
      // vertex count above the matrix size
      '{1'b1, 5'd31, CMD_BFS,   4'd2,  4'd0,  1'b0, 4'd0},
      '{1'b0, 5'd0,  CMD_DFS,   4'd14, 4'd0,  1'b0, 4'd0},
      // start not below the vertex count, then a self loop on vertex 15 at count 16
      '{1'b1, 5'd1,  CMD_DFS,   4'd1,  4'd0,  1'b0, 4'd0},
      '{1'b1, 5'd3,  CMD_BFS,   4'd15, 4'd0,  1'b0, 4'd0},
      '{1'b1, 5'd16, CMD_ADD,   4'd15, 4'd15, 1'b0, 4'd0},
      '{1'b0, 5'd0,  CMD_DFS,   4'd15, 4'd0,  1'b0, 4'd0},
      // clear empties the matrix
      '{1'b0, 5'd0,  CMD_CLEAR, 4'd15, 4'd15, 1'b0, 4'd0},
      '{1'b0, 5'd0,  CMD_BFS,   4'd15, 4'd0,  1'b1, 4'd15},
      '{1'b0, 5'd0,  CMD_DFS,   4'd0,  4'd0,  1'b1, 4'd0}
   };

   graph_bfs_dfs_traversal u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // visit order of a traversal, queued as expected results
   function automatic void predict_visit_order(input logic [CMD_W-1:0] cmd,
                                               input vertex_type start);
      int         scan_end;
      logic [NODES-1:0] seen;
      vertex_type order [$];
      vertex_type fifo [$];
      vertex_type stack_vertex [NODES];
      int         stack_column [NODES];
      int         depth;
      int         col;
      vertex_type v;
      visit_type  item;
      scan_end = (vertex_count_model > NODES) ? NODES : int'(vertex_count_model);
      seen = '0;
      seen[start] = 1'b1;
      order.push_back(start);
      if (cmd == CMD_BFS) begin
         fifo.push_back(start);
         while (fifo.size() > 0) begin
            v = fifo.pop_front();
            for (int i = 0; i < scan_end; i++) begin
               if (edge_rows[v][i] && !seen[i]) begin
                  seen[i] = 1'b1;
                  order.push_back(vertex_type'(i));
                  fifo.push_back(vertex_type'(i));
               end
            end
         end
      end else begin
         // pre-order with an explicit stack of (vertex, next column)
         stack_vertex[0] = start;
         stack_column[0] = 0;
         depth = 1;
         while (depth > 0) begin
            v   = stack_vertex[depth-1];
            col = stack_column[depth-1];
            while (col < scan_end && !(edge_rows[v][col] && !seen[col]))
               col++;
            if (col < scan_end) begin
               stack_column[depth-1] = col + 1;
               seen[col] = 1'b1;
               order.push_back(vertex_type'(col));
               if (depth < NODES) begin
                  stack_vertex[depth] = vertex_type'(col);
                  stack_column[depth] = 0;
                  depth++;
               end
            end else begin
               depth--;
            end
         end
      end
      foreach (order[k]) begin
         item.vertex = order[k];
         item.last   = (k == order.size() - 1);
         pending_visits.push_back(item);
      end
   endfunction

   // update the matrix model for an accepted request, or predict its visits
   function automatic void apply_request(input logic [CMD_W-1:0] cmd,
                                         input vertex_type first, input vertex_type second);
      case (cmd)
         CMD_CLEAR: begin
            foreach (edge_rows[r]) edge_rows[r] = '0;
         end
         CMD_ADD: begin
            edge_rows[first][second] = 1'b1;
            edge_rows[second][first] = 1'b1;
         end
         default: begin
            predict_visit_order(cmd, first);
         end
      endcase
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
   endtask

   // offer one request, wait for it to be taken, then predict
   task automatic send_request(input logic [CMD_W-1:0] cmd, input vertex_type first,
                               input vertex_type second, input bit typed,
                               input vertex_type typed_vertex);
      int        gap;
      visit_type item;
      gap = source_idle ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {second, first};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      if (cmd == CMD_BFS || cmd == CMD_DFS) traversals_sent++;
      if (typed) begin
         item.vertex = typed_vertex;
         item.last   = 1'b1;
         pending_visits.push_back(item);
      end else begin
         apply_request(cmd, first, second);
      end
   endtask

   // stop offering, wait for every expected vertex and let the block settle
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_visits.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_vertex_count(input logic [VCOUNT_W-1:0] value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      vertex_count_model = value;
      count_writes++;
   endtask

   // result receiver with random stalls and one long hold-off
   initial begin : result_sink
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (hold_request) begin
            gap = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
         $display("graph_bfs_dfs_traversal test failed");
         $finish;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_visits.size() == 0) begin
               note_error($sformatf("unexpected vertex %0d last %0b", rsp_tdata, rsp_tlast));
            end else begin
               expected_visit = pending_visits.pop_front();
               visits_checked++;
               if (rsp_tdata !== {{(RSP_DATA_W-VERTEX_W){1'b0}}, expected_visit.vertex} ||
                   rsp_tlast !== expected_visit.last)
                  note_error($sformatf("vertex expected %0d last %0b, got %0d last %0b",
                                       expected_visit.vertex, expected_visit.last,
                                       rsp_tdata, rsp_tlast));
            end
         end
      end
   end

   // stimulus
   initial begin : stimulus
      int round;
      int edge_total;
      int trav_total;
      logic [CMD_W-1:0] trav_cmd;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_CLEAR;
      csr_wr_en   = 1'b0;
      csr_wr_data = VCOUNT_RESET;
      foreach (edge_rows[r]) edge_rows[r] = '0;
      vertex_count_model = VCOUNT_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].set_count) write_vertex_count(directed_rows[r].count);
         send_request(directed_rows[r].cmd, directed_rows[r].first, directed_rows[r].second,
                      directed_rows[r].typed, directed_rows[r].typed_vertex);
      end

      // random graphs: mostly clear, a batch of edges, then traversals
      round = 0;
      while (requests_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         round++;
         source_idle = ($urandom_range(0, 3) != 0);
         sink_idle   = ($urandom_range(0, 3) != 0);
         if (round % 6 == 0) begin
            case ($urandom_range(0, 7))
               0:       write_vertex_count(5'd0);
               1:       write_vertex_count(5'd1);
               2:       write_vertex_count(5'd16);
               3:       write_vertex_count(5'd31);
               4:       write_vertex_count(VCOUNT_W'($urandom_range(17, 31)));
               default: write_vertex_count(VCOUNT_W'($urandom_range(2, 16)));
            endcase
         end
         // long receiver hold-off while requests keep coming
         if (round == 4) begin
            hold_request = 1'b1;
            source_idle  = 1'b0;
         end
         if ($urandom_range(0, 9) < 8) begin
            send_request(CMD_CLEAR, vertex_type'($urandom_range(0, 15)),
                         vertex_type'($urandom_range(0, 15)), 1'b0, '0);
            edge_total = $urandom_range(0, 30);
            repeat (edge_total)
               send_request(CMD_ADD, vertex_type'($urandom_range(0, 15)),
                            vertex_type'($urandom_range(0, 15)), 1'b0, '0);
            trav_total = $urandom_range(1, 5);
            repeat (trav_total) begin
               trav_cmd = $urandom_range(0, 1) ? CMD_BFS : CMD_DFS;
               send_request(trav_cmd, vertex_type'($urandom_range(0, 15)),
                            vertex_type'($urandom_range(0, 15)), 1'b0, '0);
            end
         end else begin
            // noise: any command with any fields
            repeat ($urandom_range(1, 8))
               send_request(CMD_W'($urandom_range(0, 3)), vertex_type'($urandom_range(0, 15)),
                            vertex_type'($urandom_range(0, 15)), 1'b0, '0);
         end
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_visits.size() != 0)
         note_error($sformatf("%0d expected vertices never arrived", pending_visits.size()));

      $display("covered %0d requests, %0d traversals, %0d vertices checked, %0d count writes",
               requests_sent, traversals_sent, visits_checked, count_writes);
      $display("receiver held off %0d cycles once; %0d errors", HOLD_CYCLES, error_count);
      if (error_count == 0) begin
         $display("graph_bfs_dfs_traversal test passed");
      end else begin
         $display("graph_bfs_dfs_traversal test failed");
      end
      $finish;
   end

endmodule
